@@ rtl/cid_pkg.sv @@
// Shared types and constants for the counted interrupt dispatcher.
package cid_pkg;

  localparam int NUM_LINES_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int MASK_WIDTH      = 16;
  localparam int LINE_OUT_WIDTH  = 5;

  // Vector ranges: 32..39 -> lines 0..7, 112..119 -> lines 8..15
  localparam logic [4:0] VEC_LO_BASE = 5'b00100;
  localparam logic [4:0] VEC_HI_BASE = 5'b01110;

  localparam logic FUNC_RAISE  = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] vector;
  } in_t;

  typedef struct packed {
    logic                      dispatched;
    logic [LINE_OUT_WIDTH-1:0] line;
    logic                      handler_busy;
    logic                      count_overflow;
    logic                      bad_vector;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic clr_busy;
    logic set_bad;
    logic rd_evt;
    logic upd_evt;
    logic rd_scan;
    logic chk_scan;
    logic idx_inc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic bad;
    logic busy;
    logic cnt_zero;
    logic has_handler;
    logic last;
  } stat_t;

endpackage

@@ rtl/cid_ctrl.sv @@
// Sequencer for event handling and the priority scan.
module cid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cid_pkg::stat_t st,
  output cid_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVT  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SCHK = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVT;
        end
      end
      ST_EVT: begin
        if (st.func == cid_pkg::FUNC_FINISH) begin
          cmd.clr_busy = 1'b1;
          state_nxt    = ST_SRD;
        end else if (st.bad) begin
          cmd.set_bad = 1'b1;
          state_nxt   = st.busy ? ST_DONE : ST_SRD;
        end else begin
          cmd.rd_evt = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd_evt = 1'b1;
        state_nxt   = st.busy ? ST_DONE : ST_SRD;
      end
      ST_SRD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_SCHK;
      end
      ST_SCHK: begin
        cmd.chk_scan = 1'b1;
        if ((!st.cnt_zero && st.has_handler) || st.last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SRD;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/cid_datapath.sv @@
// Pending-count memory, handler mask, busy flag and result register.
module cid_datapath #(
  parameter int NUM_LINES   = cid_pkg::NUM_LINES_DEF,
  parameter int COUNT_WIDTH = cid_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cid_pkg::in_t                   in_data,
  input  logic                           cfg_we,
  input  logic [cid_pkg::MASK_WIDTH-1:0] cfg_wdata,
  input  cid_pkg::cmd_t                  cmd,
  output cid_pkg::stat_t                 st,
  output cid_pkg::out_t                  out_data
);

  localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  logic [cid_pkg::MASK_WIDTH-1:0] mask_r;
  logic                           busy_r;
  logic                           func_r;
  logic [7:0]                     vector_r;
  logic [LW-1:0]                  idx_r;
  logic                           bad_r;
  logic                           ovf_r;
  logic                           disp_r;
  logic [cid_pkg::LINE_OUT_WIDTH-1:0] line_r;
  cid_pkg::out_t                  out_r;

  logic [COUNT_WIDTH-1:0] mem [NUM_LINES];
  logic [NUM_LINES-1:0]   valid_r;
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic                   rvalid_r;

  logic [3:0]             map_line;
  logic                   map_hit;
  logic [31:0]            map_ext;
  logic                   bad;
  logic [LW-1:0]          evt_addr;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   cnt_max;
  logic [31:0]            mask_sh;
  logic                   has_handler;
  logic                   we;
  logic [LW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   re;
  logic [LW-1:0]          raddr;

  // vector map
  always_comb begin
    map_line = 4'd0;
    map_hit  = 1'b0;
    if (vector_r[7:3] == cid_pkg::VEC_LO_BASE) begin
      map_line = {1'b0, vector_r[2:0]};
      map_hit  = 1'b1;
    end else if (vector_r[7:3] == cid_pkg::VEC_HI_BASE) begin
      map_line = {1'b1, vector_r[2:0]};
      map_hit  = 1'b1;
    end
  end

  assign map_ext  = 32'(map_line);
  assign bad      = !map_hit || (map_ext >= 32'(NUM_LINES));
  assign evt_addr = map_ext[LW-1:0];

  // unwritten entries read as zero
  assign cnt     = rvalid_r ? rdata_r : '0;
  assign cnt_max = (cnt == {COUNT_WIDTH{1'b1}});

  // mask bits at or above the mask width read as no handler
  assign mask_sh     = 32'(mask_r) >> idx_r;
  assign has_handler = mask_sh[0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    if (cmd.upd_evt && !cnt_max) begin
      we    = 1'b1;
      waddr = evt_addr;
      wdata = cnt + COUNT_WIDTH'(1);
    end else if (cmd.chk_scan && (cnt != '0)) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = has_handler ? (cnt - COUNT_WIDTH'(1)) : '0;
    end
  end

  assign re    = cmd.rd_evt || cmd.rd_scan;
  assign raddr = cmd.rd_evt ? evt_addr : idx_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r  <= mem[raddr];
      rvalid_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      mask_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (cmd.clr_busy) begin
        busy_r <= 1'b0;
      end else if (cmd.chk_scan && (cnt != '0) && has_handler) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_data.func;
      vector_r <= in_data.vector;
      idx_r    <= '0;
      bad_r    <= 1'b0;
      ovf_r    <= 1'b0;
      disp_r   <= 1'b0;
      line_r   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + LW'(1);
      end
      if (cmd.set_bad) begin
        bad_r <= 1'b1;
      end
      if (cmd.upd_evt && cnt_max) begin
        ovf_r <= 1'b1;
      end
      if (cmd.chk_scan && (cnt != '0) && has_handler) begin
        disp_r <= 1'b1;
        line_r <= cid_pkg::LINE_OUT_WIDTH'(32'(idx_r) + 32'd1);
      end
    end
    if (cmd.load_out) begin
      out_r.dispatched     <= disp_r;
      out_r.line           <= line_r;
      out_r.handler_busy   <= busy_r;
      out_r.count_overflow <= ovf_r;
      out_r.bad_vector     <= bad_r;
    end
  end

  assign st.func        = func_r;
  assign st.bad         = bad;
  assign st.busy        = busy_r;
  assign st.cnt_zero    = (cnt == '0);
  assign st.has_handler = has_handler;
  assign st.last        = (32'(idx_r) == 32'(NUM_LINES - 1));
  assign out_data       = out_r;

endmodule

@@ rtl/counted_interrupt_dispatcher.sv @@
// Top level of the counted interrupt dispatcher.
//
// Input channel (in_valid/in_ready/in_data): one event per transfer, either a
// raise carrying an interrupt vector or a handler-finished notice.
// Output channel (out_valid/out_ready/out_data): exactly one result per event,
// with the dispatch decision, the handler busy flag and the error flags.
// cfg_we/cfg_wdata load the handler mask; write it only while the block idles.
// An event passes the load and decode states (and the count update for a mapped
// raise), then scans lines upward from line 0, a read and a check state per
// line, until one is dispatched or the last is checked; a raise while the
// handler is busy skips the scan. The next event is taken once the result is
// loaded into the output register. The scan reads the counts through the single
// read port of the count memory; only one event is in flight at a time.
// Reset clears the mask, the busy flag and the per-line valid bits, so every
// pending count reads as zero at once; no clearing pass is needed.
// A result waits in the output register while out_ready is low; the next event
// is taken meanwhile and its result is held until the register frees up.
module counted_interrupt_dispatcher #(
  parameter int NUM_LINES   = cid_pkg::NUM_LINES_DEF,
  parameter int COUNT_WIDTH = cid_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cid_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cid_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [cid_pkg::MASK_WIDTH-1:0] cfg_wdata
);

  cid_pkg::cmd_t  cmd;
  cid_pkg::stat_t st;

  cid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  cid_datapath #(
    .NUM_LINES   (NUM_LINES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

@@ bench/tb_counted_interrupt_dispatcher.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the counted interrupt dispatcher: directed and random events.
module tb_counted_interrupt_dispatcher;

  localparam int NUM_LINES        = cid_pkg::NUM_LINES_DEF;
  localparam int COUNT_WIDTH      = cid_pkg::COUNT_WIDTH_DEF;
  localparam int MASK_WIDTH       = cid_pkg::MASK_WIDTH;
  localparam int LINE_OUT_WIDTH   = cid_pkg::LINE_OUT_WIDTH;
  localparam int SETTLE_CYCLES    = 40;     // worst event latency plus margin
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RAND_PHASE_ITEMS = 170;
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  cid_pkg::in_t          in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cid_pkg::out_t         out_data;
  logic                  cfg_we    = 1'b0;
  logic [MASK_WIDTH-1:0] cfg_wdata = '0;

  // predictor state
  logic [COUNT_WIDTH-1:0] line_pending [NUM_LINES];
  logic                   model_busy = 1'b0;
  logic [MASK_WIDTH-1:0]  model_mask = '0;

  cid_pkg::out_t expected_outcomes [$];
  int   mismatches = 0;
  int   cycles     = 0;
  int   rx_hold    = 0;
  bit   tx_quiet   = 1'b0;
  bit   rx_quiet   = 1'b0;

  counted_interrupt_dispatcher #(
    .NUM_LINES  (NUM_LINES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Apply one event to the predictor and return the result it should produce.
  function automatic cid_pkg::out_t predict_dispatch(cid_pkg::in_t ev);
    cid_pkg::out_t res;
    int   ln;
    bit   done;
    res  = '0;
    ln   = -1;
    done = 1'b0;
    if (ev.func == cid_pkg::FUNC_RAISE) begin
      if (ev.vector[7:3] == cid_pkg::VEC_LO_BASE) ln = ev.vector[2:0];
      else if (ev.vector[7:3] == cid_pkg::VEC_HI_BASE) ln = 8 + ev.vector[2:0];
      if (ln < 0 || ln >= NUM_LINES) res.bad_vector = 1'b1;
      else if (line_pending[ln] == COUNT_FULL) res.count_overflow = 1'b1;
      else line_pending[ln] = line_pending[ln] + 1'b1;
    end else begin
      model_busy = 1'b0;
    end
    // raise while busy only counts; no scan
    if (!model_busy) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (!done && line_pending[i] != '0) begin
          if (model_mask[i]) begin
            line_pending[i] = line_pending[i] - 1'b1;
            res.dispatched  = 1'b1;
            res.line        = LINE_OUT_WIDTH'(i + 1);
            model_busy      = 1'b1;
            done            = 1'b1;
          end else begin
            line_pending[i] = '0;  // no handler installed: drain
          end
        end
      end
    end
    res.handler_busy = model_busy;
    return res;
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                 field, cycles, want, got);
    end
  endtask

  // Result side: check each transfer, then draw a stall before the next one.
  always @(posedge clk) begin : result_check
    cid_pkg::out_t want;
    int   hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no event outstanding at cycle %0d: %0h", cycles, out_data);
      end else begin
        want = expected_outcomes.pop_front();
        flag_field("dispatched", want.dispatched, out_data.dispatched);
        flag_field("line", want.line, out_data.line);
        flag_field("handler_busy", want.handler_busy, out_data.handler_busy);
        flag_field("count_overflow", want.count_overflow, out_data.count_overflow);
        flag_field("bad_vector", want.bad_vector, out_data.bad_vector);
      end
      hold = rx_quiet ? 0 : $urandom_range(0, 4);
      rx_hold   <= hold;
      out_ready <= (hold == 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Entered and left at a rising edge; valid stays up when the next gap is zero.
  task automatic send_event(input logic fn, input logic [7:0] vec);
    cid_pkg::in_t ev;
    int  gap;
    ev.func   = fn;
    ev.vector = vec;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_outcomes.push_back(predict_dispatch(ev));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_handler_mask(input logic [MASK_WIDTH-1:0] mask);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_mask = mask;
  endtask

  function automatic logic [7:0] pick_vector(input int hot_line);
    int roll;
    int ln;
    roll = $urandom_range(0, 99);
    if (roll >= 75) return 8'($urandom_range(0, 255));
    ln = (roll < 40) ? hot_line : $urandom_range(0, NUM_LINES - 1);
    return (ln < 8) ? {cid_pkg::VEC_LO_BASE, 3'(ln)} : {cid_pkg::VEC_HI_BASE, 3'(ln - 8)};
  endfunction

  task automatic test_unmapped_and_idle();
    set_handler_mask(16'h0000);
    send_event(cid_pkg::FUNC_FINISH, 8'hFF);   // finish while already free
    send_event(cid_pkg::FUNC_RAISE, 8'h00);
    send_event(cid_pkg::FUNC_RAISE, 8'h1F);
    send_event(cid_pkg::FUNC_RAISE, 8'h28);
    send_event(cid_pkg::FUNC_RAISE, 8'h6F);
    send_event(cid_pkg::FUNC_RAISE, 8'h78);
    send_event(cid_pkg::FUNC_RAISE, 8'hFF);
    send_event(cid_pkg::FUNC_RAISE, 8'h20);    // mapped, no handler: dropped
    send_event(cid_pkg::FUNC_RAISE, 8'h77);
  endtask

  task automatic test_priority_dispatch();
    set_handler_mask(16'hFFFF);
    send_event(cid_pkg::FUNC_RAISE, 8'h27);    // line 7 dispatched, handler busy
    send_event(cid_pkg::FUNC_RAISE, 8'h20);
    send_event(cid_pkg::FUNC_RAISE, 8'h70);
    send_event(cid_pkg::FUNC_RAISE, 8'h80);    // bad vector while busy
    send_event(cid_pkg::FUNC_FINISH, 8'h00);   // line 0 wins over line 8
    send_event(cid_pkg::FUNC_FINISH, 8'h00);
    send_event(cid_pkg::FUNC_FINISH, 8'h00);
    send_event(cid_pkg::FUNC_FINISH, 8'h00);
  endtask

  task automatic test_drain_without_handler();
    set_handler_mask(16'h0100);
    send_event(cid_pkg::FUNC_RAISE, 8'h70);
    send_event(cid_pkg::FUNC_RAISE, 8'h21);
    send_event(cid_pkg::FUNC_RAISE, 8'h22);
    send_event(cid_pkg::FUNC_RAISE, 8'h71);
    send_event(cid_pkg::FUNC_FINISH, 8'hAA);   // lines 1, 2 and 9 drained, nothing dispatched
    send_event(cid_pkg::FUNC_FINISH, 8'h55);
  endtask

  task automatic test_count_saturation();
    set_handler_mask(16'h0001);
    send_event(cid_pkg::FUNC_RAISE, 8'h20);    // occupy the handler
    repeat (int'(COUNT_FULL) + 2) send_event(cid_pkg::FUNC_RAISE, 8'h23);
    send_event(cid_pkg::FUNC_RAISE, 8'h76);
    set_handler_mask(16'h4009);
    send_event(cid_pkg::FUNC_FINISH, 8'h00);
    send_event(cid_pkg::FUNC_FINISH, 8'h00);
    send_event(cid_pkg::FUNC_RAISE, 8'h23);
    set_handler_mask(16'h0000);
    send_event(cid_pkg::FUNC_FINISH, 8'h00);   // drains everything left
  endtask

  task automatic run_random_phase(input logic [MASK_WIDTH-1:0] mask);
    int finish_pct;
    int hot;
    set_handler_mask(mask);
    finish_pct = $urandom_range(5, 50);
    hot        = $urandom_range(0, NUM_LINES - 1);
    tx_quiet   = ($urandom_range(0, 3) == 0);
    rx_quiet   = ($urandom_range(0, 3) == 0);
    repeat (RAND_PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < finish_pct) send_event(cid_pkg::FUNC_FINISH, 8'($urandom));
      else send_event(cid_pkg::FUNC_RAISE, pick_vector(hot));
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'hFFFF);
    run_random_phase(16'h0000);
    run_random_phase(MASK_WIDTH'($urandom));
    run_random_phase(16'h8000);
    run_random_phase(16'h0001);
    run_random_phase(MASK_WIDTH'($urandom));
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_LINES; i++) line_pending[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_unmapped_and_idle();
    test_priority_dispatch();
    test_drain_without_handler();
    test_count_saturation();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ counted_interrupt_dispatcher.f @@
rtl/cid_pkg.sv
rtl/cid_ctrl.sv
rtl/cid_datapath.sv
rtl/counted_interrupt_dispatcher.sv
bench/tb_counted_interrupt_dispatcher.sv
